@@ design/ffprs_pkg.sv @@
package ffprs_pkg;

  // Default sizes
  localparam int MAX_PAGES_DEF = 16;
  localparam int MAX_SLOTS_DEF = 64;

  // Page layout
  localparam logic [15:0] HEADER_BYTES  = 16'd16;
  localparam logic [16:0] SLOT_OVERHEAD = 17'd4;
  localparam logic [15:0] PAGE_SIZE_RST = 16'd4096;

  // Result field widths
  localparam int KIND_W  = 2;
  localparam int PAGE_W  = 5;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 7;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PAGE   = 2'd3;

  // Result select codes from controller to datapath
  localparam logic [2:0] R_PLACE = 3'd0;  // insert into existing page
  localparam logic [2:0] R_OPEN  = 3'd1;  // insert into a fresh page
  localparam logic [2:0] R_FULL  = 3'd2;  // insert refused
  localparam logic [2:0] R_HIT   = 3'd3;
  localparam logic [2:0] R_MISS  = 3'd4;
  localparam logic [2:0] R_TOTAL = 3'd5;
  localparam logic [2:0] R_PAGE  = 3'd6;

  typedef struct packed {
    logic       load;       // capture item, rewind scan
    logic       page_step;  // advance page pointer
    logic       srch_step;  // issue one key read, advance slot/page
    logic       emit;       // load the result register
    logic [2:0] res;        // which result to form
  } ffprs_cmd_t;

  typedef struct packed {
    logic page_end;   // page pointer past last page in use
    logic page_fit;   // current page takes the record
    logic full;       // no page left to open
    logic rd_hit;     // key read back matches
    logic srch_end;   // nothing issued, nothing in flight
    logic last_page;  // current page is the last in use
    logic empty;      // no page in use
  } ffprs_stat_t;

endpackage

@@ design/first_fit_page_record_store.sv @@
// Channel   Handshake                   Payload
// -------   -------------------------   ----------------------------------------------
// item in   start, busy (start & !busy)  operation, record_size, key
// result    result_valid                 result_kind, ok, page_index, slot_index,
//                                        count, last
// config    APB, pready tied high        paddr, pwdata -> page_size; prdata readback
//
// Insert: examines pages in order for the first fit; else opens a page or refuses.
// Search: one key-store read per stored record up to the hit; the single-port key
//   memory read sets the pace.
// Status: a total result, then one per page in use, one result per cycle.
// A new item can be taken in the cycle its predecessor's final result is shown.
// Reset (rst, synchronous) empties the page set and sets page_size to 4096;
// per-page tables and keys need no clearing. The receiver cannot stall.
module first_fit_page_record_store #(
  parameter int MAX_PAGES = ffprs_pkg::MAX_PAGES_DEF,
  parameter int MAX_SLOTS = ffprs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item in
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            operation,
  input  logic [15:0]                           record_size,
  input  logic signed [31:0]                    key,
  // results
  output logic                                  result_valid,
  output logic [ffprs_pkg::KIND_W-1:0]          result_kind,
  output logic                                  ok,
  output logic signed [ffprs_pkg::PAGE_W-1:0]   page_index,
  output logic signed [ffprs_pkg::SLOT_W-1:0]   slot_index,
  output logic [ffprs_pkg::COUNT_W-1:0]         count,
  output logic                                  last,
  // config
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam logic REG_PAGE_SIZE = 1'b0;  // paddr[2] selects the register

  logic [15:0]            page_size;
  logic                   cfg_wr;
  ffprs_pkg::ffprs_cmd_t  cmd;
  ffprs_pkg::ffprs_stat_t stat;

  // Config register; software must write it only while the block is idle; the block does not enforce this
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PAGE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= ffprs_pkg::PAGE_SIZE_RST;
    end else if (cfg_wr) begin
      page_size <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_PAGE_SIZE) ? {16'd0, page_size} : 32'd0;

  ffprs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  ffprs_dp #(
    .MAX_PAGES (MAX_PAGES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .page_size    (page_size),
    .record_size  (record_size),
    .key          (key),
    .stat         (stat),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .ok           (ok),
    .page_index   (page_index),
    .slot_index   (slot_index),
    .count        (count),
    .last         (last)
  );

  // Dropping out of busy always coincides with the final result transfer
  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (result_valid && last))
    else $error("busy fell without a final result");

  // More results pending means the block is still working
  a_nonlast_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("non-final result while idle");

  // A final result is never directly followed by another transfer
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result right after a final result");

  // Every page in use holds at least one record
  a_page_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_kind == ffprs_pkg::KIND_PAGE)) |-> (count != '0))
    else $error("reported page holds no record");

endmodule

@@ design/ffprs_ctrl.sv @@
module ffprs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             operation,
  input  ffprs_pkg::ffprs_stat_t stat,
  output logic                   busy,
  output ffprs_pkg::ffprs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_PAGE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (operation)
            ffprs_pkg::OP_INSERT: state_next = S_INS;
            ffprs_pkg::OP_SEARCH: state_next = S_SRCH;
            ffprs_pkg::OP_STATUS: state_next = S_HEAD;
            default:              state_next = S_IDLE;  // unused code, dropped
          endcase
        end
      end
      S_INS: begin
        priority if (stat.page_end) begin
          cmd.emit   = 1'b1;
          cmd.res    = stat.full ? ffprs_pkg::R_FULL : ffprs_pkg::R_OPEN;
          state_next = S_IDLE;
        end else if (stat.page_fit) begin
          cmd.emit   = 1'b1;
          cmd.res    = ffprs_pkg::R_PLACE;
          state_next = S_IDLE;
        end else begin
          cmd.page_step = 1'b1;
        end
      end
      S_SRCH: begin
        priority if (stat.rd_hit) begin
          cmd.emit   = 1'b1;
          cmd.res    = ffprs_pkg::R_HIT;
          state_next = S_IDLE;
        end else if (stat.srch_end) begin
          cmd.emit   = 1'b1;
          cmd.res    = ffprs_pkg::R_MISS;
          state_next = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.emit   = 1'b1;
        cmd.res    = ffprs_pkg::R_TOTAL;
        state_next = stat.empty ? S_IDLE : S_PAGE;
      end
      S_PAGE: begin
        cmd.emit      = 1'b1;
        cmd.res       = ffprs_pkg::R_PAGE;
        cmd.page_step = 1'b1;
        if (stat.last_page) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/ffprs_dp.sv @@
module ffprs_dp #(
  parameter int MAX_PAGES = ffprs_pkg::MAX_PAGES_DEF,
  parameter int MAX_SLOTS = ffprs_pkg::MAX_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ffprs_pkg::ffprs_cmd_t                 cmd,
  input  logic [15:0]                           page_size,
  input  logic [15:0]                           record_size,
  input  logic [31:0]                           key,
  output ffprs_pkg::ffprs_stat_t                stat,
  output logic                                  result_valid,
  output logic [ffprs_pkg::KIND_W-1:0]          result_kind,
  output logic                                  ok,
  output logic signed [ffprs_pkg::PAGE_W-1:0]   page_index,
  output logic signed [ffprs_pkg::SLOT_W-1:0]   slot_index,
  output logic [ffprs_pkg::COUNT_W-1:0]         count,
  output logic                                  last
);

  localparam int PW = $clog2(MAX_PAGES + 1);                 // page count
  localparam int PI = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1; // page index
  localparam int SW = $clog2(MAX_SLOTS + 1);                 // record count
  localparam int SI = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1; // slot index
  localparam int AW = PI + SI;
  localparam int KEY_DEPTH = 1 << AW;
  localparam int PAGE_W  = ffprs_pkg::PAGE_W;
  localparam int SLOT_W  = ffprs_pkg::SLOT_W;
  localparam int COUNT_W = ffprs_pkg::COUNT_W;

  // Item registers
  logic [16:0] need;
  logic [31:0] key_q;

  // Scan pointers
  logic [PW-1:0] p;
  logic [SI-1:0] s;
  logic [PW-1:0] pages_in_use;

  // Per-page tables, never cleared: only pages in use are read
  logic [15:0]   free_mem [0:MAX_PAGES-1];
  logic [SW-1:0] rec_mem  [0:MAX_PAGES-1];

  // Key store
  logic [31:0]   key_mem [0:KEY_DEPTH-1];
  logic [31:0]   rd_data;
  logic          rd_valid;
  logic [PI-1:0] rd_p;
  logic [SI-1:0] rd_s;

  logic [PI-1:0] pi;
  logic [15:0]   cur_free;
  logic [SW-1:0] cur_rec;
  logic [15:0]   cap;
  logic [15:0]   open_free;
  logic          do_place;
  logic          do_open;
  logic          issue;
  logic          slot_wrap;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign pi       = p[PI-1:0];
  assign cur_free = free_mem[pi];
  assign cur_rec  = rec_mem[pi];

  assign do_place = cmd.emit && (cmd.res == ffprs_pkg::R_PLACE);
  assign do_open  = cmd.emit && (cmd.res == ffprs_pkg::R_OPEN);

  // Free bytes of a fresh page; both the header and an oversize record clamp at 0
  assign cap       = (page_size > ffprs_pkg::HEADER_BYTES) ?
                     (page_size - ffprs_pkg::HEADER_BYTES) : '0;
  assign open_free = ({1'b0, cap} >= need) ? (cap - need[15:0]) : '0;

  assign stat.page_end  = (p >= pages_in_use);
  assign stat.page_fit  = (cur_rec < SW'(MAX_SLOTS)) && ({1'b0, cur_free} >= need);
  assign stat.full      = (pages_in_use >= PW'(MAX_PAGES));
  assign stat.rd_hit    = rd_valid && (rd_data == key_q);
  assign stat.srch_end  = !rd_valid && stat.page_end;
  assign stat.last_page = ((p + PW'(1)) == pages_in_use);
  assign stat.empty     = (pages_in_use == '0);

  assign issue     = cmd.srch_step && !stat.page_end;
  assign slot_wrap = ((SW'(s) + SW'(1)) == cur_rec);
  assign raddr     = {pi, s};
  assign waddr     = {pi, do_open ? SI'(0) : cur_rec[SI-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need  <= {1'b0, record_size} + ffprs_pkg::SLOT_OVERHEAD;
      key_q <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p            <= '0;
      s            <= '0;
      pages_in_use <= '0;
      rd_valid     <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (cmd.load) begin
        p <= '0;
        s <= '0;
      end else if (cmd.page_step) begin
        p <= p + PW'(1);
      end else if (issue) begin
        if (slot_wrap) begin
          p <= p + PW'(1);
          s <= '0;
        end else begin
          s <= s + SI'(1);
        end
      end
      if (do_open) begin
        pages_in_use <= pages_in_use + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_p <= pi;
      rd_s <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (do_place) begin
      free_mem[pi] <= cur_free - need[15:0];
      rec_mem[pi]  <= cur_rec + SW'(1);
    end else if (do_open) begin
      free_mem[pi] <= open_free;
      rec_mem[pi]  <= SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_place || do_open) begin
      key_mem[waddr] <= key_q;
    end
    if (issue) begin
      rd_data <= key_mem[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ok         <= 1'b0;
      page_index <= '0;
      slot_index <= '0;
      count      <= '0;
      last       <= 1'b1;
      unique case (cmd.res)
        ffprs_pkg::R_PLACE: begin
          result_kind <= ffprs_pkg::KIND_INSERT;
          ok          <= 1'b1;
          page_index  <= PAGE_W'(p);
          slot_index  <= SLOT_W'(cur_rec);
        end
        ffprs_pkg::R_OPEN: begin
          result_kind <= ffprs_pkg::KIND_INSERT;
          ok          <= 1'b1;
          page_index  <= PAGE_W'(p);
        end
        ffprs_pkg::R_FULL: begin
          result_kind <= ffprs_pkg::KIND_INSERT;
          page_index  <= '1;
          slot_index  <= '1;
        end
        ffprs_pkg::R_HIT: begin
          result_kind <= ffprs_pkg::KIND_SEARCH;
          ok          <= 1'b1;
          page_index  <= PAGE_W'(rd_p);
          slot_index  <= SLOT_W'(rd_s);
        end
        ffprs_pkg::R_MISS: begin
          result_kind <= ffprs_pkg::KIND_SEARCH;
          page_index  <= '1;
          slot_index  <= '1;
        end
        ffprs_pkg::R_TOTAL: begin
          result_kind <= ffprs_pkg::KIND_TOTAL;
          count       <= COUNT_W'(pages_in_use);
          last        <= stat.empty;
        end
        ffprs_pkg::R_PAGE: begin
          result_kind <= ffprs_pkg::KIND_PAGE;
          page_index  <= PAGE_W'(p);
          count       <= COUNT_W'(cur_rec);
          last        <= stat.last_page;
        end
        default: begin
          result_kind <= ffprs_pkg::KIND_INSERT;
        end
      endcase
    end
  end

endmodule
